### hw/rtl/cdiv_pkg.sv
// Shared widths, codes and reset values for the clock divider search block.
package cdiv_pkg;

   // Field widths
   localparam int unsigned FREQ_W    = 28;
   localparam int unsigned DIV_W     = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // Numerator (source plus half divider) needs one more bit than a frequency
   localparam int unsigned NUM_W      = FREQ_W + 1;
   // Reciprocal scale: 2**QUOT_SHIFT / divider, exact to within one LSB of quotient
   localparam int unsigned QUOT_SHIFT = NUM_W;
   localparam int unsigned RECIP_W    = NUM_W;
   localparam int unsigned DIV_RANGE  = 1 << DIV_W;

   // Tolerance for a match, inclusive
   localparam logic [FREQ_W-1:0] TOL_HZ = FREQ_W'(2);

   // Divider range default
   localparam int unsigned MAX_DIVIDER_DEF = 255;

   // Register reset values
   localparam logic [FREQ_W-1:0] SRC_A_RESET = FREQ_W'(160000000);
   localparam logic [FREQ_W-1:0] SRC_B_RESET = FREQ_W'(240000000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_A = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_B = CSR_IDX_W'(1);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_EXACT   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_NEAREST = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_NONE    = STATUS_W'(2);

endpackage

### hw/rtl/cdiv_if.sv
// Handshake channel interfaces for request, response and register writes.
interface cdiv_req_if;
   import cdiv_pkg::*;
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] target_hz;

   modport source (output valid, output target_hz, input ready);
   modport sink   (input valid, input target_hz, output ready);
endinterface

interface cdiv_rsp_if;
   import cdiv_pkg::*;
   logic                valid;
   logic                ready;
   logic                source_index;
   logic [DIV_W-1:0]    divider;
   logic [FREQ_W-1:0]   achieved_hz;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output source_index, output divider,
                   output achieved_hz, output status, input ready);
   modport sink   (input valid, input source_index, input divider,
                   input achieved_hz, input status, output ready);
endinterface

interface cdiv_csr_if;
   import cdiv_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [FREQ_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/clock_divider_search.sv
// Clock divider search: one candidate per cycle through a pipelined reciprocal divider.
// Sequence: the sweep covers both sources and every divider from 2 to MAX_DIVIDER, then the
//   pipeline drains and the response word is registered and held until the receiver takes it.
// Requests: one at a time; a new request is taken only in idle, after the response word is
//   accepted, so response stalls hold off the next request.
// Reset: synchronous; sources return to 160 MHz and 240 MHz, sequencer to idle.
module clock_divider_search #(
   parameter int unsigned MAX_DIVIDER = cdiv_pkg::MAX_DIVIDER_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cdiv_req_if.sink   req,
   cdiv_rsp_if.source rsp,
   cdiv_csr_if.sink   csr
);
   import cdiv_pkg::*;

   localparam logic [DIV_W-1:0] MaxDiv = DIV_W'(MAX_DIVIDER);
   localparam logic [DIV_W-1:0] MinDiv = DIV_W'(2);

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_DONE} state_type;

   typedef struct packed {
      logic              found;
      logic              src;
      logic [DIV_W-1:0]  div;
      logic [FREQ_W-1:0] freq;
   } pick_type;

   state_type           state_ff;
   logic [FREQ_W-1:0]   src_a_ff;
   logic [FREQ_W-1:0]   src_b_ff;
   logic [FREQ_W-1:0]   target_ff;
   logic                src_sel_ff;
   logic [DIV_W-1:0]    div_ff;

   logic                rsp_valid_ff;
   logic                rsp_src_ff;
   logic [DIV_W-1:0]    rsp_div_ff;
   logic [FREQ_W-1:0]   rsp_freq_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Reciprocal table, built at elaboration
   logic [RECIP_W-1:0]  recip_tab [DIV_RANGE];

   for (genvar g = 0; g < DIV_RANGE; g++) begin : g_recip
      localparam longint unsigned DivG     = (g < 2) ? 1 : g;
      localparam longint unsigned RecipVal = (64'd1 << QUOT_SHIFT) / DivG;
      assign recip_tab[g] = (g < 2) ? '0 : RECIP_W'(RecipVal);
   end

   // Configuration registers, always ready
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_a_ff <= SRC_A_RESET;
         src_b_ff <= SRC_B_RESET;
      end else if (csr.valid) begin
         if (csr.index == CSR_SRC_A) begin
            src_a_ff <= csr.data;
         end else if (csr.index == CSR_SRC_B) begin
            src_b_ff <= csr.data;
         end
      end
   end

   // Issue stage: numerator and reciprocal for the current candidate
   logic [FREQ_W-1:0]  src_f_in;
   logic               vld0_in;
   logic [NUM_W-1:0]   num_in;
   logic               start_in;

   assign start_in = (state_ff == ST_IDLE) && req.valid;
   assign src_f_in = src_sel_ff ? src_b_ff : src_a_ff;
   assign vld0_in  = (state_ff == ST_SWEEP) && (src_f_in != '0);
   assign num_in   = NUM_W'(src_f_in) + NUM_W'(div_ff >> 1);

   // Pipeline registers
   logic               p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff;
   logic               p1_src_ff, p2_src_ff, p3_src_ff, p4_src_ff, p5_src_ff;
   logic [DIV_W-1:0]   p1_d_ff, p2_d_ff, p3_d_ff, p4_d_ff, p5_d_ff;
   logic [NUM_W-1:0]   p1_n_ff, p2_n_ff, p3_n_ff;
   logic [RECIP_W-1:0] p1_m_ff;
   logic [NUM_W-1:0]   p2_q_ff, p3_q_ff;
   logic [NUM_W-1:0]   p3_qd_ff;
   logic [FREQ_W-1:0]  p4_r_ff, p5_r_ff;
   logic [FREQ_W-1:0]  p5_err_ff;

   logic [NUM_W+RECIP_W-1:0] prod_in;
   logic [NUM_W-1:0]         quot_in;
   logic [NUM_W+DIV_W-1:0]   qd_in;
   logic [NUM_W-1:0]         rem_in;
   logic [NUM_W-1:0]         qfix_in;
   logic [FREQ_W-1:0]        err_in;
   logic                     pipe_busy;

   // Quotient estimate is the true quotient or one short
   assign prod_in = p1_n_ff * p1_m_ff;
   assign quot_in = prod_in[NUM_W+RECIP_W-1:QUOT_SHIFT];
   // Back-multiply for the correction
   assign qd_in   = p2_q_ff * p2_d_ff;
   // Correct by one where the remainder still holds a whole divider
   assign rem_in  = p3_n_ff - p3_qd_ff;
   assign qfix_in = p3_q_ff + NUM_W'(rem_in >= NUM_W'(p3_d_ff));
   // Absolute error against the target
   assign err_in  = (p4_r_ff > target_ff) ? (p4_r_ff - target_ff) : (target_ff - p4_r_ff);

   assign pipe_busy = p1_vld_ff | p2_vld_ff | p3_vld_ff | p4_vld_ff | p5_vld_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= vld0_in;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      p1_src_ff <= src_sel_ff;
      p1_d_ff   <= div_ff;
      p1_n_ff   <= num_in;
      p1_m_ff   <= recip_tab[div_ff];

      p2_src_ff <= p1_src_ff;
      p2_d_ff   <= p1_d_ff;
      p2_n_ff   <= p1_n_ff;
      p2_q_ff   <= quot_in;

      p3_src_ff <= p2_src_ff;
      p3_d_ff   <= p2_d_ff;
      p3_n_ff   <= p2_n_ff;
      p3_q_ff   <= p2_q_ff;
      p3_qd_ff  <= qd_in[NUM_W-1:0];

      p4_src_ff <= p3_src_ff;
      p4_d_ff   <= p3_d_ff;
      p4_r_ff   <= qfix_in[FREQ_W-1:0];

      p5_src_ff <= p4_src_ff;
      p5_d_ff   <= p4_d_ff;
      p5_r_ff   <= p4_r_ff;
      p5_err_ff <= err_in;
   end

   // Trackers: first even match, first match, least error
   pick_type          even_ff, any_ff, best_ff;
   logic [FREQ_W-1:0] least_gap_ff;
   logic              within_in;
   pick_type          cand_in;

   assign within_in = (p5_err_ff <= TOL_HZ);
   assign cand_in   = '{found: 1'b1, src: p5_src_ff, div: p5_d_ff, freq: p5_r_ff};

   always_ff @(posedge clock) begin
      if (reset || start_in) begin
         even_ff.found <= 1'b0;
         any_ff.found  <= 1'b0;
         best_ff.found <= 1'b0;
      end else if (p5_vld_ff) begin
         if (within_in && !p5_d_ff[0] && !even_ff.found) begin
            even_ff <= cand_in;
         end
         if (within_in && !any_ff.found) begin
            any_ff <= cand_in;
         end
         if (!best_ff.found || (p5_err_ff < least_gap_ff)) begin
            best_ff      <= cand_in;
            least_gap_ff <= p5_err_ff;
         end
      end
   end

   // Final choice in pass order
   pick_type            pick_in;
   logic [STATUS_W-1:0] status_in;

   always_comb begin
      pick_in   = '0;
      status_in = STATUS_NONE;
      priority if (even_ff.found) begin
         pick_in   = even_ff;
         status_in = STATUS_EXACT;
      end else if (any_ff.found) begin
         pick_in   = any_ff;
         status_in = STATUS_EXACT;
      end else if (best_ff.found) begin
         pick_in   = best_ff;
         status_in = STATUS_NEAREST;
      end else begin
         pick_in   = '0;
         status_in = STATUS_NONE;
      end
   end

   // Sequencer: sweep sources and dividers, drain, hold the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         src_sel_ff   <= 1'b0;
         div_ff       <= MinDiv;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  target_ff  <= req.target_hz;
                  src_sel_ff <= 1'b0;
                  div_ff     <= MinDiv;
                  state_ff   <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (div_ff == MaxDiv) begin
                  div_ff     <= MinDiv;
                  src_sel_ff <= ~src_sel_ff;
                  if (src_sel_ff) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  div_ff <= div_ff + DIV_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  rsp_src_ff    <= pick_in.src;
                  rsp_div_ff    <= pick_in.div;
                  rsp_freq_ff   <= pick_in.freq;
                  rsp_status_ff <= status_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.source_index = rsp_src_ff;
   assign rsp.divider      = rsp_div_ff;
   assign rsp.achieved_hz  = rsp_freq_ff;
   assign rsp.status       = rsp_status_ff;

   // Checks
   logic [FREQ_W-1:0] rsp_err;
   assign rsp_err = (rsp_freq_ff > target_ff) ? (rsp_freq_ff - target_ff)
                                              : (target_ff - rsp_freq_ff);

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response word is pending");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_NONE) |->
         (rsp.divider == '0 && rsp.achieved_hz == '0 && !rsp.source_index))
      else $error("no-source response carries non-zero fields");

   a_div_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_NONE) |->
         (rsp.divider >= MinDiv && rsp.divider <= MaxDiv))
      else $error("divider outside the searched range");

   a_exact_in_tol: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_EXACT) |-> (rsp_err <= TOL_HZ))
      else $error("exact status with error beyond tolerance");

endmodule

### test/cdiv_search_checker.sv
// Checker for the clock divider search: watches all three channels, predicts and compares.
module cdiv_search_checker
   import cdiv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cdiv_req_if         req_mon,
   cdiv_rsp_if         rsp_mon,
   cdiv_csr_if         csr_mon,
   output int unsigned error_count,
   output int unsigned outstanding,
   output int unsigned in_tolerance_count,
   output int unsigned nearest_count,
   output int unsigned no_source_count
);

   // One predicted selection, tagged with the target that asked for it
   typedef struct packed {
      logic [FREQ_W-1:0]   target_hz;
      logic                source_index;
      logic [DIV_W-1:0]    divider;
      logic [FREQ_W-1:0]   achieved_hz;
      logic [STATUS_W-1:0] status;
   } divider_choice_type;

   logic [FREQ_W-1:0]  src_a_hz;
   logic [FREQ_W-1:0]  src_b_hz;
   divider_choice_type pending_choices [$];

   // Sweep tolerance on even dividers, then on any divider, then settle for the nearest
   function automatic divider_choice_type search_divider(input logic [FREQ_W-1:0] target_hz);
      logic [FREQ_W-1:0]  sources [2];
      logic [31:0]        rate;
      logic [31:0]        err;
      logic [31:0]        least_gap;
      divider_choice_type best;
      sources[0] = src_a_hz;
      sources[1] = src_b_hz;
      best       = '{target_hz, 1'b0, '0, '0, STATUS_NONE};
      least_gap  = '1;
      for (int pass = 0; pass < 3; pass++) begin
         for (int s = 0; s < 2; s++) begin
            if (sources[s] == '0) continue;
            for (int d = 2; d <= MAX_DIVIDER_DEF; d++) begin
               if (pass == 0 && d % 2 != 0) continue;
               rate = (32'(sources[s]) + 32'(d / 2)) / 32'(d);
               err  = (rate > 32'(target_hz)) ? rate - 32'(target_hz)
                                              : 32'(target_hz) - rate;
               if (pass < 2) begin
                  if (err <= 32'(TOL_HZ))
                     return '{target_hz, 1'(s), DIV_W'(d), FREQ_W'(rate), STATUS_EXACT};
               end else if (best.status == STATUS_NONE || err < least_gap) begin
                  // strictly smaller only, so the earliest candidate keeps a tie
                  best      = '{target_hz, 1'(s), DIV_W'(d), FREQ_W'(rate), STATUS_NEAREST};
                  least_gap = err;
               end
            end
         end
      end
      return best;
   endfunction

   // Print one line and count; keep the log short on a badly broken run
   task automatic report_mismatch(input string msg);
      if (error_count < 40)
         $display("[%0t] cdiv check: %s", $time, msg);
      error_count++;
   endtask

   // Track register writes, queue a prediction per request word, check each response word
   always @(posedge clock) begin
      divider_choice_type want;
      if (reset) begin
         src_a_hz = SRC_A_RESET;
         src_b_hz = SRC_B_RESET;
         pending_choices.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_SRC_A)
               src_a_hz = csr_mon.data;
            else if (csr_mon.index == CSR_SRC_B)
               src_b_hz = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready)
            pending_choices.push_back(search_divider(req_mon.target_hz));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_choices.size() == 0) begin
               report_mismatch($sformatf("response word with no request waiting (div %0d)",
                                         rsp_mon.divider));
            end else begin
               want = pending_choices.pop_front();
               if (rsp_mon.source_index !== want.source_index)
                  report_mismatch($sformatf("target %0d: source_index %0d, expected %0d",
                                            want.target_hz, rsp_mon.source_index,
                                            want.source_index));
               if (rsp_mon.divider !== want.divider)
                  report_mismatch($sformatf("target %0d: divider %0d, expected %0d",
                                            want.target_hz, rsp_mon.divider, want.divider));
               if (rsp_mon.achieved_hz !== want.achieved_hz)
                  report_mismatch($sformatf("target %0d: achieved_hz %0d, expected %0d",
                                            want.target_hz, rsp_mon.achieved_hz,
                                            want.achieved_hz));
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("target %0d: status %0d, expected %0d",
                                            want.target_hz, rsp_mon.status, want.status));
               case (want.status)
                  STATUS_EXACT:   in_tolerance_count++;
                  STATUS_NEAREST: nearest_count++;
                  default:        no_source_count++;
               endcase
            end
         end
      end
      outstanding <= pending_choices.size();
   end

endmodule

### test/tb_clock_divider_search.sv
// Testbench top for the clock divider search: clock, reset, stimulus, pacing and verdict.
module tb_clock_divider_search;
   import cdiv_pkg::*;

   localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;
   localparam int unsigned       DRAIN_CYCLES = 520;
   localparam int unsigned       CYCLE_LIMIT  = 6_000_000;

   typedef enum {RX_OPEN, RX_CHOPPY, RX_HELD} rx_mode_t;

   logic clock;
   logic reset;

   cdiv_req_if req_bus ();
   cdiv_rsp_if rsp_bus ();
   cdiv_csr_if csr_bus ();

   int unsigned error_count;
   int unsigned outstanding;
   int unsigned in_tolerance_count;
   int unsigned nearest_count;
   int unsigned no_source_count;

   int unsigned       burst_left;
   int unsigned       targets_sent;
   int unsigned       settings_used;
   int unsigned       cycle_count;
   logic [FREQ_W-1:0] cur_a_hz;
   logic [FREQ_W-1:0] cur_b_hz;

   // Directed targets: extremes, tolerance edges, odd-only matches and ties
   logic [FREQ_W-1:0] reset_targets [14] = '{
      0, 1, 2, FREQ_MAX, 80000000, 80000002, 80000003, 79999997,
      53333333, 100000000, 40000000, 627451, 627448, 941176};
   logic [FREQ_W-1:0] split_targets [2]  = '{50000000, 75000000};
   logic [FREQ_W-1:0] none_targets [3]   = '{0, 12345, FREQ_MAX};
   logic [FREQ_W-1:0] a_max_targets [3]  = '{134217728, 0, FREQ_MAX};
   logic [FREQ_W-1:0] b_max_targets [2]  = '{1052688, 1};

   clock_divider_search i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   cdiv_search_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_bus),
      .rsp_mon            (rsp_bus),
      .csr_mon            (csr_bus),
      .error_count        (error_count),
      .outstanding        (outstanding),
      .in_tolerance_count (in_tolerance_count),
      .nearest_count      (nearest_count),
      .no_source_count    (no_source_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response channel in stretches: open, choppy or held
   initial begin
      int unsigned stretch;
      int unsigned pick;
      rx_mode_t    mode;
      rsp_bus.ready <= 1'b0;
      forever begin
         stretch = $urandom_range(1, 64);
         pick    = $urandom_range(0, 3);
         mode    = (pick < 2) ? RX_OPEN : ((pick == 2) ? RX_CHOPPY : RX_HELD);
         repeat (stretch) begin
            @(posedge clock);
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_CHOPPY: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default:   rsp_bus.ready <= 1'b0;
            endcase
         end
      end
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cycle limit of %0d reached with %0d words outstanding", CYCLE_LIMIT,
               outstanding);
      $display("[clock_divider_search] ERROR");
      $finish;
   end

   // Source values: off, extremes, tiny, anywhere, or a typical clock
   function automatic logic [FREQ_W-1:0] pick_source();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return FREQ_MAX;
         2:       return FREQ_W'($urandom_range(1, 1000));
         3:       return FREQ_W'($urandom_range(1, FREQ_MAX));
         default: return FREQ_W'($urandom_range(1000000, 250000000));
      endcase
   endfunction

   // Targets: mostly near a real candidate so the tolerance passes get exercised
   function automatic logic [FREQ_W-1:0] pick_target();
      logic [FREQ_W-1:0] src;
      int unsigned       d;
      int                near;
      case ($urandom_range(0, 9))
         0, 1: return FREQ_W'($urandom);
         2:    return FREQ_W'($urandom_range(0, 3000));
         9:    return ($urandom_range(0, 1) == 0) ? '0 : FREQ_MAX;
         default: begin
            src = ($urandom_range(0, 1) == 0) ? cur_a_hz : cur_b_hz;
            if (src == '0)
               src = cur_a_hz | cur_b_hz;
            d    = $urandom_range(2, MAX_DIVIDER_DEF);
            near = int'((32'(src) + d / 2) / d) + int'($urandom_range(0, 8)) - 4;
            if (near < 0)
               near = 0;
            return FREQ_W'(near);
         end
      endcase
   endfunction

   // Offer one target word, pacing the sender in bursts with gaps between them
   task automatic send_target(input logic [FREQ_W-1:0] target);
      int unsigned gap;
      int unsigned pick;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         pick       = $urandom_range(0, 19);
         gap        = (pick < 5) ? 0 : ((pick < 17) ? $urandom_range(1, 24)
                                                    : $urandom_range(1, 700));
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.target_hz <= target;
      do @(posedge clock); while (!req_bus.ready);
      targets_sent++;
   endtask

   // Drop the request and wait until every response word has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_source(input logic [CSR_IDX_W-1:0] idx,
                               input logic [FREQ_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Reprogram both sources while idle, in random order
   task automatic write_sources(input logic [FREQ_W-1:0] a_hz, input logic [FREQ_W-1:0] b_hz);
      settle();
      if ($urandom_range(0, 1) == 0) begin
         write_source(CSR_SRC_A, a_hz);
         write_source(CSR_SRC_B, b_hz);
      end else begin
         write_source(CSR_SRC_B, b_hz);
         write_source(CSR_SRC_A, a_hz);
      end
      csr_bus.valid <= 1'b0;
      cur_a_hz = a_hz;
      cur_b_hz = b_hz;
      settings_used++;
   endtask

   // Main sequence
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.target_hz <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_SRC_A;
      csr_bus.data      <= '0;
      burst_left    = 0;
      targets_sent  = 0;
      settings_used = 1;
      cur_a_hz      = SRC_A_RESET;
      cur_b_hz      = SRC_B_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of both sources
      foreach (reset_targets[i]) send_target(reset_targets[i]);
      repeat (100) send_target(pick_target());

      // odd divider on the first source against an even one on the second
      write_sources(150000000, 100000000);
      foreach (split_targets[i]) send_target(split_targets[i]);
      repeat (80) send_target(pick_target());

      // no source available
      write_sources('0, '0);
      foreach (none_targets[i]) send_target(none_targets[i]);
      repeat (40) send_target(pick_target());

      // one source at full scale, the other off
      write_sources(FREQ_MAX, '0);
      foreach (a_max_targets[i]) send_target(a_max_targets[i]);
      repeat (90) send_target(pick_target());

      write_sources('0, FREQ_MAX);
      foreach (b_max_targets[i]) send_target(b_max_targets[i]);
      repeat (90) send_target(pick_target());

      // tiny sources, where most candidates round to zero
      write_sources(1, 2);
      repeat (60) send_target(pick_target());

      repeat (8) begin
         write_sources(pick_source(), pick_source());
         repeat (85) send_target(pick_target());
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d target words over %0d source settings in %0d cycles", targets_sent,
               settings_used, cycle_count);
      $display("results: %0d in tolerance, %0d nearest only, %0d without a source",
               in_tolerance_count, nearest_count, no_source_count);
      if (error_count == 0)
         $display("[clock_divider_search] OK");
      else
         $display("[clock_divider_search] ERROR");
      $finish;
   end

endmodule

### files.f
hw/rtl/cdiv_pkg.sv
hw/rtl/cdiv_if.sv
hw/rtl/clock_divider_search.sv
test/cdiv_search_checker.sv
test/tb_clock_divider_search.sv
